/* rtl/wcs_pkg.sv */
// Shared constants, codes and control structs for the windowed counter statistics block.
// No dependencies; every other file of the block but wcs_ram imports this package.
package wcs_pkg;

    localparam int NUM_COUNTERS = 16;
    localparam int HIST_DEPTH   = 10;
    localparam int COUNT_W      = 32;
    localparam int NUM_STATS    = 7;

    localparam int CIDX_W  = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;
    localparam int SLOT_W  = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int FILL_W  = $clog2(HIST_DEPTH + 1);
    localparam int KIND_W  = 3;
    localparam int STEP_W  = $clog2(COUNT_W);
    localparam int CMD_W   = 3;
    localparam int MASK_W  = 16;
    localparam int BKT_W   = 16;
    localparam int WORD_W  = 32;
    localparam int PADDR_W = 3;

    localparam int RING_AW    = SLOT_W + CIDX_W;
    localparam int RING_DEPTH = HIST_DEPTH << CIDX_W;
    localparam int STAT_AW    = KIND_W + CIDX_W;
    localparam int STAT_DEPTH = NUM_STATS << CIDX_W;

    localparam logic [BKT_W-1:0] BUCKET_RESET = BKT_W'(1000);

    // command codes
    localparam logic [CMD_W-1:0] CMD_ADD  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MAX  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TICK = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ = 3'd4;

    // statistic kinds
    localparam logic [KIND_W-1:0] STAT_COUNT = 3'd0;
    localparam logic [KIND_W-1:0] STAT_SUM   = 3'd1;
    localparam logic [KIND_W-1:0] STAT_AVG   = 3'd2;
    localparam logic [KIND_W-1:0] STAT_DEV   = 3'd3;
    localparam logic [KIND_W-1:0] STAT_MIN   = 3'd4;
    localparam logic [KIND_W-1:0] STAT_MAX   = 3'd5;
    localparam logic [KIND_W-1:0] STAT_LAST  = 3'd6;
    localparam logic [KIND_W-1:0] STAT_NONE  = 3'd7;

    // register select (paddr bit 2)
    localparam logic REG_GAUGE_MASK = 1'b0;
    localparam logic REG_BUCKET_MS  = 1'b1;

    typedef struct packed {
        logic live_op;
        logic tick;
        logic rd_issue;
        logic out_load;
        logic copy_we;
        logic copy_done;
        logic c_clr;
        logic c_inc;
        logic smp_init;
        logic acc_clr;
        logic p1_acc;
        logic p2_acc;
        logic div_start;
        logic div_sel;
        logic avg_load;
        logic dev_load;
        logic k_clr;
        logic k_inc;
        logic stat_we;
        logic live_clr;
    } t_dp_cmd;

    typedef struct packed {
        logic close;
        logic c_last;
        logic i_last;
        logic k_last;
        logic div_done;
        logic out_busy;
    } t_dp_status;

endpackage

/* rtl/wcs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/wcs_div.sv */
// Restoring divider, one quotient bit per cycle, for a small divisor.
// Depends on wcs_pkg.
module wcs_div import wcs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [COUNT_W-1:0] i_dividend,
    input  logic [FILL_W-1:0]  i_divisor,
    output logic               o_done,
    output logic [COUNT_W-1:0] o_quotient
);

    logic [COUNT_W-1:0] r_q;
    logic [FILL_W-1:0]  r_rem;
    logic [FILL_W-1:0]  r_div;
    logic [STEP_W-1:0]  r_step;
    logic               r_busy;
    logic               r_done;

    logic [FILL_W:0]    rem_sh;
    logic               ge;
    logic [FILL_W:0]    rem_sub;

    always_comb begin
        rem_sh  = {r_rem, r_q[COUNT_W-1]};
        ge      = rem_sh >= {1'b0, r_div};
        rem_sub = ge ? (rem_sh - {1'b0, r_div}) : rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == STEP_W'(COUNT_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q    <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
            r_step <= '0;
        end else if (r_busy) begin
            r_q    <= {r_q[COUNT_W-2:0], ge};
            r_rem  <= rem_sub[FILL_W-1:0];
            r_step <= r_step + 1'b1;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

/* rtl/wcs_dp.sv */
// Datapath: live counters, history ring, statistic table, accumulators, output register.
// Depends on wcs_pkg, wcs_ram and wcs_div.
module wcs_dp import wcs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd_ctl,
    output t_dp_status         o_st,
    input  logic [MASK_W-1:0]  i_gauge_mask,
    input  logic [BKT_W-1:0]   i_bucket_ms,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [CIDX_W-1:0]  i_counter_index,
    input  logic [COUNT_W-1:0] i_operand_value,
    input  logic [WORD_W-1:0]  i_now_ms,
    input  logic [KIND_W-1:0]  i_stat_kind,
    input  logic               i_stat_ready,
    output logic               o_stat_valid,
    output logic [WORD_W-1:0]  o_stat_value
);

    logic [COUNT_W-1:0] r_live [NUM_COUNTERS];
    logic [WORD_W-1:0]  r_deadline;
    logic [SLOT_W-1:0]  r_wslot, r_rslot;
    logic [FILL_W-1:0]  r_filled, r_i, r_cnt;
    logic [CIDX_W-1:0]  r_c;
    logic [KIND_W-1:0]  r_k;
    logic [COUNT_W-1:0] r_sum, r_mn, r_mx, r_last, r_avg, r_dev;
    logic               r_stats_ok, r_rd_zero;
    logic               r_out_valid;
    logic [WORD_W-1:0]  r_out_value;

    logic [COUNT_W-1:0] ring_q, stat_q, cur, live_nxt, absd, stat_wd, div_q;
    logic [SLOT_W-1:0]  oldest, rslot_inc;
    logic               smp_ok, now_ge, div_done;
    logic [KIND_W-1:0]  rd_kind;
    logic [FILL_W-1:0]  divisor;

    always_comb begin
        cur = r_live[i_counter_index];
        unique case (i_cmd)
            CMD_ADD: live_nxt = cur + i_operand_value;
            CMD_SET: live_nxt = i_operand_value;
            CMD_MAX: live_nxt = (i_operand_value > cur) ? i_operand_value : cur;
            default: live_nxt = cur;
        endcase
        now_ge    = i_now_ms >= r_deadline;
        oldest    = (r_filled < FILL_W'(HIST_DEPTH)) ? '0 : r_wslot;
        rslot_inc = (r_rslot == SLOT_W'(HIST_DEPTH - 1)) ? '0 : r_rslot + 1'b1;
        smp_ok    = !(i_gauge_mask[r_c] && ring_q == '1);
        absd      = (ring_q > r_avg) ? (ring_q - r_avg) : (r_avg - ring_q);
        divisor   = (r_cnt == '0) ? FILL_W'(1) : r_cnt;
        rd_kind   = (i_stat_kind == STAT_NONE) ? STAT_COUNT : i_stat_kind;
        unique case (r_k)
            STAT_COUNT: stat_wd = COUNT_W'(r_cnt);
            STAT_SUM:   stat_wd = r_sum;
            STAT_AVG:   stat_wd = r_avg;
            STAT_DEV:   stat_wd = r_dev;
            STAT_MIN:   stat_wd = (r_cnt == '0) ? '0 : r_mn;
            STAT_MAX:   stat_wd = r_mx;
            STAT_LAST:  stat_wd = r_last;
            default:    stat_wd = '0;
        endcase
    end

    // live counters; the copy pass rotates them so entry 0 is always the one sent
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NUM_COUNTERS; j++) begin
                r_live[j] <= '0;
            end
        end else if (i_cmd_ctl.live_clr) begin
            for (int j = 0; j < NUM_COUNTERS; j++) begin
                r_live[j] <= i_gauge_mask[j] ? '1 : '0;
            end
        end else if (i_cmd_ctl.copy_we) begin
            for (int j = 0; j < NUM_COUNTERS; j++) begin
                r_live[j] <= r_live[(j + 1) % NUM_COUNTERS];
            end
        end else if (i_cmd_ctl.live_op) begin
            r_live[i_counter_index] <= live_nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadline  <= '0;
            r_wslot     <= '0;
            r_filled    <= '0;
            r_stats_ok  <= 1'b0;
            r_out_valid <= 1'b0;
            r_c         <= '0;
            r_k         <= '0;
        end else begin
            if (i_cmd_ctl.tick && now_ge) begin
                r_deadline <= i_now_ms + WORD_W'(i_bucket_ms);
            end
            if (i_cmd_ctl.copy_done) begin
                r_wslot <= (r_wslot == SLOT_W'(HIST_DEPTH - 1)) ? '0 : r_wslot + 1'b1;
                if (r_filled < FILL_W'(HIST_DEPTH)) begin
                    r_filled <= r_filled + 1'b1;
                end
            end
            if (i_cmd_ctl.live_clr) begin
                r_stats_ok <= 1'b1;
            end
            if (i_cmd_ctl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_stat_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd_ctl.c_clr) begin
                r_c <= '0;
            end else if (i_cmd_ctl.c_inc) begin
                r_c <= r_c + 1'b1;
            end
            if (i_cmd_ctl.k_clr) begin
                r_k <= '0;
            end else if (i_cmd_ctl.k_inc) begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    // walk and accumulators
    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.rd_issue) begin
            r_rd_zero <= (i_stat_kind == STAT_NONE) || !r_stats_ok;
        end
        if (i_cmd_ctl.out_load) begin
            r_out_value <= r_rd_zero ? '0 : stat_q;
        end
        if (i_cmd_ctl.smp_init) begin
            r_i     <= '0;
            r_rslot <= oldest;
        end else if (i_cmd_ctl.p1_acc || i_cmd_ctl.p2_acc) begin
            r_i     <= r_i + 1'b1;
            r_rslot <= rslot_inc;
        end
        if (i_cmd_ctl.acc_clr) begin
            r_cnt  <= '0;
            r_sum  <= '0;
            r_mn   <= '1;
            r_mx   <= '0;
            r_last <= '0;
            r_dev  <= '0;
        end else if (i_cmd_ctl.p1_acc && smp_ok) begin
            r_cnt  <= r_cnt + 1'b1;
            r_sum  <= r_sum + ring_q;
            r_last <= ring_q;
            if (ring_q < r_mn) begin
                r_mn <= ring_q;
            end
            if (ring_q > r_mx) begin
                r_mx <= ring_q;
            end
        end else if (i_cmd_ctl.p2_acc && smp_ok) begin
            r_dev <= r_dev + absd;
        end else if (i_cmd_ctl.dev_load) begin
            r_dev <= div_q;
        end
        if (i_cmd_ctl.avg_load) begin
            r_avg <= div_q;
        end
    end

    wcs_ram #(.WIDTH(COUNT_W), .DEPTH(RING_DEPTH)) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd_ctl.copy_we),
        .i_waddr ({r_wslot, r_c}),
        .i_wdata (r_live[0]),
        .i_raddr ({r_rslot, r_c}),
        .o_rdata (ring_q)
    );

    wcs_ram #(.WIDTH(COUNT_W), .DEPTH(STAT_DEPTH)) u_stat (
        .i_clk   (i_clk),
        .i_we    (i_cmd_ctl.stat_we),
        .i_waddr ({r_k, r_c}),
        .i_wdata (stat_wd),
        .i_raddr ({rd_kind, i_counter_index}),
        .o_rdata (stat_q)
    );

    wcs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd_ctl.div_start),
        .i_dividend (i_cmd_ctl.div_sel ? r_dev : r_sum),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_comb begin
        o_st.close    = now_ge && (r_deadline != '0);
        o_st.c_last   = r_c == CIDX_W'(NUM_COUNTERS - 1);
        o_st.i_last   = r_i == (r_filled - 1'b1);
        o_st.k_last   = r_k == KIND_W'(NUM_STATS - 1);
        o_st.div_done = div_done;
        o_st.out_busy = r_out_valid && !i_stat_ready;
    end

    assign o_stat_valid = r_out_valid;
    assign o_stat_value = r_out_value;

endmodule

/* rtl/wcs_ctrl.sv */
// Controller state machine: command dispatch and the bucket-closing sequence.
// Depends on wcs_pkg.
module wcs_ctrl import wcs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [CMD_W-1:0] i_cmd,
    output logic             o_ready,
    input  t_dp_status       i_st,
    output t_dp_cmd          o_dp
);

    typedef enum logic [13:0] {
        S_IDLE   = 14'h0001,
        S_READ   = 14'h0002,
        S_COPY   = 14'h0004,
        S_SETUP  = 14'h0008,
        S_P1_RD  = 14'h0010,
        S_P1_AC  = 14'h0020,
        S_AVG_GO = 14'h0040,
        S_DIV1   = 14'h0080,
        S_P2_RD  = 14'h0100,
        S_P2_AC  = 14'h0200,
        S_DEV_GO = 14'h0400,
        S_DIV2   = 14'h0800,
        S_WSTAT  = 14'h1000,
        S_CLEAR  = 14'h2000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_ready = (r_state == S_IDLE) && ((i_cmd != CMD_READ) || !i_st.out_busy);
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        o_dp    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_cmd)
                        CMD_ADD, CMD_SET, CMD_MAX: o_dp.live_op = 1'b1;
                        CMD_TICK: begin
                            o_dp.tick  = 1'b1;
                            o_dp.c_clr = 1'b1;
                            if (i_st.close) begin
                                n_state = S_COPY;
                            end
                        end
                        CMD_READ: begin
                            o_dp.rd_issue = 1'b1;
                            n_state       = S_READ;
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                o_dp.out_load = 1'b1;
                n_state       = S_IDLE;
            end
            S_COPY: begin
                o_dp.copy_we = 1'b1;
                o_dp.c_inc   = 1'b1;
                if (i_st.c_last) begin
                    o_dp.copy_done = 1'b1;
                    o_dp.c_clr     = 1'b1;
                    n_state        = S_SETUP;
                end
            end
            S_SETUP: begin
                o_dp.smp_init = 1'b1;
                o_dp.acc_clr  = 1'b1;
                n_state       = S_P1_RD;
            end
            S_P1_RD: n_state = S_P1_AC;
            S_P1_AC: begin
                o_dp.p1_acc = 1'b1;
                n_state     = i_st.i_last ? S_AVG_GO : S_P1_RD;
            end
            S_AVG_GO: begin
                o_dp.div_start = 1'b1;
                n_state        = S_DIV1;
            end
            S_DIV1: begin
                if (i_st.div_done) begin
                    o_dp.avg_load = 1'b1;
                    o_dp.smp_init = 1'b1;
                    n_state       = S_P2_RD;
                end
            end
            S_P2_RD: n_state = S_P2_AC;
            S_P2_AC: begin
                o_dp.p2_acc = 1'b1;
                n_state     = i_st.i_last ? S_DEV_GO : S_P2_RD;
            end
            S_DEV_GO: begin
                o_dp.div_start = 1'b1;
                o_dp.div_sel   = 1'b1;
                n_state        = S_DIV2;
            end
            S_DIV2: begin
                if (i_st.div_done) begin
                    o_dp.dev_load = 1'b1;
                    o_dp.k_clr    = 1'b1;
                    n_state       = S_WSTAT;
                end
            end
            S_WSTAT: begin
                o_dp.stat_we = 1'b1;
                o_dp.k_inc   = 1'b1;
                if (i_st.k_last) begin
                    if (i_st.c_last) begin
                        n_state = S_CLEAR;
                    end else begin
                        o_dp.c_inc = 1'b1;
                        n_state    = S_SETUP;
                    end
                end
            end
            S_CLEAR: begin
                o_dp.live_clr = 1'b1;
                n_state       = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/windowed_counter_statistics_top.sv */
// Top level of the windowed counter statistics block: APB registers, controller, datapath.
// Depends on wcs_pkg, wcs_ctrl and wcs_dp.
//
//  channel  | handshake                  | word
//  ---------+----------------------------+--------------------------------------------
//  command  | i_valid / o_ready          | i_cmd, i_counter_index, i_operand_value,
//           |                            | i_now_ms, i_stat_kind
//  result   | o_stat_valid / i_stat_ready| o_stat_value (read commands only)
//  config   | psel/penable/pwrite/pready | paddr, pwdata, prdata (0 gauge mask, 4 bucket)
//
// Add, set, max, ignored codes and a tick that does not close are handled without leaving S_IDLE.
// Read: statistic RAM registered read, then output register. In S_IDLE a read is
// held off only while the previous result word still waits; other words are taken.
// A closing tick: copy pass, then per counter a walk and a 32-step divide for the average,
// another for the deviation and a write of each statistic kind, then the clear state.
// Reset is synchronous, active low; the ring RAM is not cleared, stat reads return
// 0 until the first bucket has closed, so no clearing pass is needed.
module windowed_counter_statistics_top import wcs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [CIDX_W-1:0]  i_counter_index,
    input  logic [COUNT_W-1:0] i_operand_value,
    input  logic [WORD_W-1:0]  i_now_ms,
    input  logic [KIND_W-1:0]  i_stat_kind,
    // result channel
    output logic               o_stat_valid,
    input  logic               i_stat_ready,
    output logic [WORD_W-1:0]  o_stat_value,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [WORD_W-1:0]  pwdata,
    output logic [WORD_W-1:0]  prdata,
    output logic               pready
);

    logic [MASK_W-1:0] r_gauge_mask;
    logic [BKT_W-1:0]  r_bucket_ms;
    t_dp_cmd           dp_cmd;
    t_dp_status        dp_st;

    // registers; bit 2 of the address picks the register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gauge_mask <= '0;
            r_bucket_ms  <= BUCKET_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_GAUGE_MASK) begin
                r_gauge_mask <= pwdata[MASK_W-1:0];
            end else begin
                r_bucket_ms <= pwdata[BKT_W-1:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BUCKET_MS) ? WORD_W'(r_bucket_ms)
                                                : WORD_W'(r_gauge_mask);

    wcs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_cmd   (i_cmd),
        .o_ready (o_ready),
        .i_st    (dp_st),
        .o_dp    (dp_cmd)
    );

    wcs_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_ctl       (dp_cmd),
        .o_st            (dp_st),
        .i_gauge_mask    (r_gauge_mask),
        .i_bucket_ms     (r_bucket_ms),
        .i_cmd           (i_cmd),
        .i_counter_index (i_counter_index),
        .i_operand_value (i_operand_value),
        .i_now_ms        (i_now_ms),
        .i_stat_kind     (i_stat_kind),
        .i_stat_ready    (i_stat_ready),
        .o_stat_valid    (o_stat_valid),
        .o_stat_value    (o_stat_value)
    );

endmodule

/* rtl/wcs_chk.sv */
// Port-level checker for the windowed counter statistics block, bound to the top level.
// Depends on wcs_pkg and windowed_counter_statistics_top.
module wcs_chk import wcs_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic [CMD_W-1:0]   i_cmd,
    input logic [KIND_W-1:0]  i_stat_kind,
    input logic               o_stat_valid,
    input logic               i_stat_ready,
    input logic [WORD_W-1:0]  o_stat_value
);

    logic rd_acc;
    assign rd_acc = i_valid && o_ready && (i_cmd == CMD_READ);

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_stat_valid)
        else $error("result word valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat_valid && !i_stat_ready |=> o_stat_valid && $stable(o_stat_value))
        else $error("stalled result word changed");

    a_rd_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_acc |-> ##2 o_stat_valid)
        else $error("read word not delivered two cycles after accept");

    a_rd_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_acc && (i_stat_kind == STAT_NONE) |-> ##2 (o_stat_value == '0))
        else $error("unknown statistic kind did not read as zero");

endmodule

bind windowed_counter_statistics_top wcs_chk u_wcs_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .i_cmd        (i_cmd),
    .i_stat_kind  (i_stat_kind),
    .o_stat_valid (o_stat_valid),
    .i_stat_ready (i_stat_ready),
    .o_stat_value (o_stat_value)
);

/* sim/wcs_checker.sv */
// Checker for windowed_counter_statistics_top: watches command, result and register writes,
// predicts every statistic read and compares it with the result word. Depends on wcs_pkg.
`timescale 1ns / 100ps
module wcs_checker import wcs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_ready,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [CIDX_W-1:0]  i_counter_index,
    input  logic [COUNT_W-1:0] i_operand_value,
    input  logic [WORD_W-1:0]  i_now_ms,
    input  logic [KIND_W-1:0]  i_stat_kind,
    input  logic               i_stat_valid,
    input  logic               i_stat_ready,
    input  logic [WORD_W-1:0]  i_stat_value,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [WORD_W-1:0]  i_pwdata,
    output int                 o_fail_count,
    output int                 o_pending
);
    localparam logic [COUNT_W-1:0] NO_VALUE = '1;

    logic [MASK_W-1:0]  gauge_bits;
    logic [BKT_W-1:0]   bucket_len;
    logic [COUNT_W-1:0] live [NUM_COUNTERS];
    logic [COUNT_W-1:0] ring [HIST_DEPTH][NUM_COUNTERS];
    logic [COUNT_W-1:0] stats [NUM_STATS][NUM_COUNTERS];
    int                 wr_slot;
    int                 fill;
    logic [WORD_W-1:0]  deadline;
    logic [WORD_W-1:0]  expected_stats [$];

    assign o_pending = expected_stats.size();

    function automatic bit holds_value(int c, logic [COUNT_W-1:0] v);
        return !(gauge_bits[c] && v == NO_VALUE);
    endfunction

    task automatic clear_live();
        for (int c = 0; c < NUM_COUNTERS; c++)
            live[c] = gauge_bits[c] ? NO_VALUE : '0;
    endtask

    // recompute all seven statistics over the valid samples in the ring
    task automatic summarize_ring();
        logic [COUNT_W-1:0] cnt, sum, mn, mx, last, avg, dev, v;
        int oldest;
        oldest = (fill < HIST_DEPTH) ? 0 : wr_slot;
        for (int c = 0; c < NUM_COUNTERS; c++) begin
            cnt = 0; sum = 0; mn = NO_VALUE; mx = 0; last = 0; avg = 0; dev = 0;
            for (int i = 0; i < fill; i++) begin
                v = ring[(oldest + i) % HIST_DEPTH][c];
                if (holds_value(c, v)) begin
                    cnt++;
                    sum = sum + v;
                    if (v < mn) mn = v;
                    if (v > mx) mx = v;
                    last = v;
                end
            end
            if (cnt > 0) avg = sum / cnt;
            else mn = 0;
            for (int i = 0; i < fill; i++) begin
                v = ring[i][c];
                if (holds_value(c, v))
                    dev = dev + ((v > avg) ? v - avg : avg - v);
            end
            dev = dev / ((cnt > 0) ? cnt : 1);
            stats[STAT_COUNT][c] = cnt;
            stats[STAT_SUM][c]   = sum;
            stats[STAT_AVG][c]   = avg;
            stats[STAT_DEV][c]   = dev;
            stats[STAT_MIN][c]   = mn;
            stats[STAT_MAX][c]   = mx;
            stats[STAT_LAST][c]  = last;
        end
    endtask

    task automatic apply_word();
        case (i_cmd)
            CMD_ADD: live[i_counter_index] = live[i_counter_index] + i_operand_value;
            CMD_SET: live[i_counter_index] = i_operand_value;
            CMD_MAX: if (i_operand_value > live[i_counter_index])
                live[i_counter_index] = i_operand_value;
            CMD_TICK: if (i_now_ms >= deadline) begin
                if (deadline != 0) begin
                    for (int c = 0; c < NUM_COUNTERS; c++) ring[wr_slot][c] = live[c];
                    wr_slot = (wr_slot + 1) % HIST_DEPTH;
                    if (fill < HIST_DEPTH) fill++;
                    summarize_ring();
                    clear_live();
                end
                deadline = i_now_ms + WORD_W'(bucket_len);
            end
            CMD_READ: expected_stats.push_back((i_stat_kind < NUM_STATS) ?
                stats[i_stat_kind][i_counter_index] : '0);
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            gauge_bits = '0;
            bucket_len = BUCKET_RESET;
            wr_slot = 0;
            fill = 0;
            deadline = '0;
            o_fail_count = 0;
            expected_stats.delete();
            for (int k = 0; k < NUM_STATS; k++)
                for (int c = 0; c < NUM_COUNTERS; c++) stats[k][c] = '0;
            clear_live();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_BUCKET_MS) bucket_len = i_pwdata[BKT_W-1:0];
                else gauge_bits = i_pwdata[MASK_W-1:0];
            end
            if (i_valid && i_ready) apply_word();
            if (i_stat_valid && i_stat_ready) begin
                if (expected_stats.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, actual %h",
                             $realtime, i_stat_value);
                    o_fail_count++;
                end else begin
                    if (i_stat_value !== expected_stats[0]) begin
                        $display("%0t: stat_value mismatch, expected %h, actual %h",
                                 $realtime, expected_stats[0], i_stat_value);
                        o_fail_count++;
                    end
                    void'(expected_stats.pop_front());
                end
            end
        end
    end
endmodule

/* sim/windowed_counter_statistics_top_tb.sv */
// Testbench top for windowed_counter_statistics_top: stimulus, handshake idling and verdict.
// Depends on wcs_pkg, the block and sim/wcs_checker.sv.
`timescale 1ns / 100ps
module windowed_counter_statistics_top_tb;
    import wcs_pkg::*;

    localparam int CLOSE_CYCLES = 2000;   // covers a full closing tick

    // unused command codes, the block ignores them
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

    // register byte addresses
    localparam logic [PADDR_W-1:0] ADDR_GAUGE_MASK = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_BUCKET_MS  = 3'd4;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [CMD_W-1:0]   i_cmd = CMD_ADD;
    logic [CIDX_W-1:0]  i_counter_index = '0;
    logic [COUNT_W-1:0] i_operand_value = '0;
    logic [WORD_W-1:0]  i_now_ms = '0;
    logic [KIND_W-1:0]  i_stat_kind = STAT_COUNT;
    logic               o_stat_valid;
    logic               i_stat_ready = 1'b0;
    logic [WORD_W-1:0]  o_stat_value;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [WORD_W-1:0]  pwdata = '0;
    logic [WORD_W-1:0]  prdata;
    logic               pready;

    int fail_count;
    int pending_reads;

    // sender burst state, receiver hold-off request
    int          burst_left = 0;
    bit          hold_off_req = 0;
    logic [31:0] clock_ms = 32'd0;
    logic [BKT_W-1:0] cur_bucket = BUCKET_RESET;

    windowed_counter_statistics_top i_dut (.*);

    wcs_checker i_checker (
        .i_clk, .i_rst_n, .i_valid, .i_ready(o_ready), .i_cmd, .i_counter_index,
        .i_operand_value, .i_now_ms, .i_stat_kind, .i_stat_valid(o_stat_valid),
        .i_stat_ready, .i_stat_value(o_stat_value), .i_psel(psel), .i_penable(penable),
        .i_pwrite(pwrite), .i_pready(pready), .i_paddr(paddr), .i_pwdata(pwdata),
        .o_fail_count(fail_count), .o_pending(pending_reads)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Offer one command word and wait for it to be taken. Between bursts the valid
    // may drop for a random gap; within a burst it stays high across words.
    task automatic send_word(logic [CMD_W-1:0] cmd, logic [CIDX_W-1:0] idx,
                             logic [COUNT_W-1:0] val, logic [WORD_W-1:0] now,
                             logic [KIND_W-1:0] kind);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_valid         <= 1'b1;
        i_cmd           <= cmd;
        i_counter_index <= idx;
        i_operand_value <= val;
        i_now_ms        <= now;
        i_stat_kind     <= kind;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Let every read come back and any closing pass finish before a register write.
    task automatic drain();
        i_valid <= 1'b0;
        burst_left = 0;
        while (pending_reads != 0) @(posedge i_clk);
        repeat (CLOSE_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [PADDR_W-1:0] addr, logic [WORD_W-1:0] data);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 5))
            0: return '1;                       // gauge no-value marker
            1: return '0;
            2, 3: return $urandom_range(0, 1000);
            default: return $urandom();
        endcase
    endfunction

    // Random word mix: mostly counter updates and reads, a few ticks and junk codes.
    task automatic random_word();
        int r;
        logic [31:0] now;
        r = $urandom_range(0, 99);
        if (r < 30) send_word(CMD_ADD, CIDX_W'($urandom()), pick_operand(), $urandom(),
                              KIND_W'($urandom()));
        else if (r < 45) send_word(CMD_SET, CIDX_W'($urandom()), pick_operand(), $urandom(),
                                   KIND_W'($urandom()));
        else if (r < 58) send_word(CMD_MAX, CIDX_W'($urandom()), pick_operand(), $urandom(),
                                   KIND_W'($urandom()));
        else if (r < 92) send_word(CMD_READ, CIDX_W'($urandom()), $urandom(), $urandom(),
                                   ($urandom_range(0, 15) == 0) ? STAT_NONE
                                       : KIND_W'($urandom_range(0, 6)));
        else if (r < 97) begin
            case ($urandom_range(0, 9))
                0: now = $urandom();                         // arbitrary jump
                1, 2: now = clock_ms + $urandom_range(0, 3); // usually early
                default: now = clock_ms + cur_bucket + $urandom_range(0, 50);
            endcase
            clock_ms = now;
            send_word(CMD_TICK, CIDX_W'($urandom()), $urandom(), now, KIND_W'($urandom()));
        end else
            send_word(CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)),
                      CIDX_W'($urandom()), $urandom(), $urandom(), KIND_W'($urandom()));
    endtask

    task automatic set_config(logic [MASK_W-1:0] mask, logic [BKT_W-1:0] bkt);
        drain();
        reg_write(ADDR_GAUGE_MASK, {16'h0, mask});
        reg_write(ADDR_BUCKET_MS, {16'h0, bkt});
        cur_bucket = bkt;
    endtask

    // Receiver: now and then changes its stall mode at random, and on request
    // holds off for a long counted stretch so reads back up into the input.
    initial begin
        int mode;
        mode = 0;
        forever begin
            if (hold_off_req) begin
                i_stat_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_off_req = 0;
            end
            if ($urandom_range(0, 199) == 0) mode = $urandom_range(0, 2);
            case (mode)
                0: i_stat_ready <= 1'b1;
                1: i_stat_ready <= 1'($urandom_range(0, 1));
                default: i_stat_ready <= ($urandom_range(0, 7) != 0);
            endcase
            @(posedge i_clk);
        end
    end

    initial begin
        #30_000_000;
        $display("windowed_counter_statistics_top test failed");
        $finish;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reads before any close, junk codes, timer start, wraps, marker
        send_word(CMD_READ, 4'd0, '0, '0, STAT_COUNT);
        send_word(CMD_READ, 4'd15, '0, '0, STAT_NONE);
        send_word(CMD_UNUSED_LO, 4'd1, '1, '0, STAT_SUM);
        send_word(CMD_UNUSED_HI, 4'd2, '1, '0, STAT_SUM);
        send_word(CMD_TICK, 4'd0, '0, 32'd0, STAT_COUNT);       // starts the timer
        send_word(CMD_ADD, 4'd0, '1, '0, STAT_COUNT);
        send_word(CMD_ADD, 4'd0, 32'd2, '0, STAT_COUNT);        // wraps to 1
        send_word(CMD_SET, 4'd15, '1, '0, STAT_COUNT);
        send_word(CMD_MAX, 4'd15, 32'd0, '0, STAT_COUNT);
        send_word(CMD_MAX, 4'd3, 32'd12345, '0, STAT_COUNT);
        send_word(CMD_TICK, 4'd0, '0, 32'd999, STAT_COUNT);     // too early
        send_word(CMD_TICK, 4'd0, '0, 32'd1000, STAT_COUNT);    // closes
        for (int k = 0; k < 8; k++)
            send_word(CMD_READ, (k % 2) ? 4'd15 : 4'd0, '0, '0, KIND_W'(k));
        send_word(CMD_TICK, 4'd0, '0, 32'hFFFF_FC18, STAT_COUNT); // deadline wraps to 0
        send_word(CMD_TICK, 4'd0, '0, 32'd5, STAT_COUNT);        // restarts timer only
        send_word(CMD_READ, 4'd3, '1, '1, STAT_MAX);
        clock_ms = 32'd5;

        // long receiver hold-off while reads keep coming
        hold_off_req = 1;
        for (int n = 0; n < 40; n++)
            send_word(CMD_READ, CIDX_W'($urandom()), '0, '0, KIND_W'($urandom_range(0, 6)));

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: set_config(16'hFFFF, 16'd1);
                1: set_config(16'h00F0, 16'd0);       // zero bucket: most ticks close
                2: set_config(16'hA5A5, 16'hFFFF);
                3: set_config(16'h0000, 16'd1000);
                4: set_config(16'h5A5A, 16'd7);
                default: set_config(MASK_W'($urandom()), BKT_W'($urandom_range(0, 200)));
            endcase
            for (int n = 0; n < 270; n++) random_word();
        end

        drain();
        if (fail_count == 0)
            $display("windowed_counter_statistics_top test passed");
        else
            $display("windowed_counter_statistics_top test failed");
        $finish;
    end
endmodule

/* files.f */
rtl/wcs_pkg.sv
rtl/wcs_ram.sv
rtl/wcs_div.sv
rtl/wcs_dp.sv
rtl/wcs_ctrl.sv
rtl/windowed_counter_statistics_top.sv
rtl/wcs_chk.sv
sim/wcs_checker.sv
sim/windowed_counter_statistics_top_tb.sv
